// ===== src/gcb_pkg.sv =====
// ----------------------------------------------------------------------------
// gcb_pkg
// shared types, codes and sizes of the graph coloring backtrack unit
// ----------------------------------------------------------------------------
package gcb_pkg;

   // fixed field widths of the transaction payloads
   localparam int TYPE_W   = 2;
   localparam int NODE_W   = 6;
   localparam int COLOR_W  = 4;
   localparam int STATUS_W = 3;
   localparam int DATA_W   = 16;

   // tdata layout, lowest bit up
   localparam int NODE_A_LSB = 0;
   localparam int NODE_B_LSB = NODE_W;
   localparam int RSP_NODE_LSB  = 0;
   localparam int RSP_COLOR_LSB = NODE_W;

   // wide enough to compare any node number against any node count
   localparam int CMP_W      = NODE_W + 1;
   // one bit per color code, code 0 included
   localparam int COLOR_SPAN = 1 << COLOR_W;
   // next color to try, may run one past the largest code
   localparam int START_W    = COLOR_W + 1;

   localparam int DEF_MAX_NODES  = 32;
   localparam int DEF_MAX_COLORS = 15;

   localparam logic [NODE_W-1:0]  NODE_COUNT_RESET  = '0;
   localparam logic [COLOR_W-1:0] COLOR_COUNT_RESET = COLOR_W'(4);

   typedef enum logic [TYPE_W-1:0] {
      REQ_SET_EDGE   = 2'd0,
      REQ_CLEAR_EDGE = 2'd1,
      REQ_START      = 2'd2
   } gcb_req_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_EDGE_OK  = 3'd0,
      ST_BAD_NODE = 3'd1,
      ST_NOT_ADJ  = 3'd2,
      ST_FOUND    = 3'd3,
      ST_NONE     = 3'd4
   } gcb_status_type;

   typedef enum logic {
      CSR_NODE_COUNT  = 1'b0,
      CSR_COLOR_COUNT = 1'b1
   } gcb_csr_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EDGE_A_WR,
      S_EDGE_B_RD,
      S_EDGE_B_WR,
      S_SINGLE_RSP,
      S_ROW_RD,
      S_ROW_CAP,
      S_SCAN,
      S_PICK,
      S_BACK,
      S_OUT_RD,
      S_OUT_EMIT
   } gcb_state_type;

   // one result handed from the sequencer to the output register
   typedef struct packed {
      logic                valid;
      gcb_status_type      status;
      logic [NODE_W-1:0]   node;
      logic [COLOR_W-1:0]  color;
      logic                last;
   } gcb_rsp_type;

endpackage

// ===== src/gcb_ram.sv =====
// ----------------------------------------------------------------------------
// gcb_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module gcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/gcb_ctrl.sv =====
// ----------------------------------------------------------------------------
// gcb_ctrl
// request sequencer: edge updates and backtracking search over the rams
// ----------------------------------------------------------------------------
module gcb_ctrl
   import gcb_pkg::*;
#(
   parameter int MAX_NODES = DEF_MAX_NODES,
   parameter int NW        = $clog2(MAX_NODES + 1),
   parameter int AW        = $clog2(MAX_NODES)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [TYPE_W-1:0]  req_kind,
   input  logic [NODE_W-1:0]  node_a,
   input  logic [NODE_W-1:0]  node_b,
   input  logic [NW-1:0]      n_eff,
   input  logic [COLOR_W-1:0] c_eff,
   input  logic               slot_free,
   output gcb_rsp_type        emit,
   // adjacency ram
   output logic               adj_we,
   output logic [AW-1:0]      adj_waddr,
   output logic [MAX_NODES-1:0] adj_wdata,
   output logic               adj_re,
   output logic [AW-1:0]      adj_raddr,
   input  logic [MAX_NODES-1:0] adj_rdata,
   // node color ram
   output logic               col_we,
   output logic [AW-1:0]      col_waddr,
   output logic [COLOR_W-1:0] col_wdata,
   output logic               col_re,
   output logic [AW-1:0]      col_raddr,
   input  logic [COLOR_W-1:0] col_rdata
);

   gcb_state_type state_ff, state_in;

   logic [AW-1:0]         a_ff, a_in;
   logic [AW-1:0]         b_ff, b_in;
   logic                  clear_ff, clear_in;
   gcb_status_type        status_ff, status_in;
   logic [NW-1:0]         cur_ff, cur_in;
   logic [START_W-1:0]    start_ff, start_in;
   logic [NW-1:0]         scan_ff, scan_in;
   logic                  pend_ff, pend_in;
   logic [COLOR_SPAN-1:0] used_ff, used_in;
   logic [MAX_NODES-1:0]  row_ff, row_in;
   logic [AW-1:0]         radr_ff, radr_in;
   logic [MAX_NODES-1:0]  valid_ff, valid_in;
   logic [NW-1:0]         out_ff, out_in;

   logic                  accept;
   logic                  bad_node;
   logic [MAX_NODES-1:0]  adj_row;
   logic [MAX_NODES-1:0]  one_hot_b;
   logic [MAX_NODES-1:0]  one_hot_a;
   logic [COLOR_W-1:0]    pick;
   logic                  pick_ok;
   logic                  scan_more;
   logic                  out_last;

   assign accept   = req_valid && req_ready;
   assign bad_node = (node_a == '0) || (node_b == '0) ||
                     (CMP_W'(node_a) > CMP_W'(n_eff)) || (CMP_W'(node_b) > CMP_W'(n_eff));

   // rows never written read as empty
   assign adj_row   = valid_ff[radr_ff] ? adj_rdata : '0;
   assign one_hot_b = MAX_NODES'(1) << b_ff;
   assign one_hot_a = MAX_NODES'(1) << a_ff;
   assign scan_more = scan_ff < cur_ff;
   assign out_last  = out_ff == n_eff;

   // lowest color in start..c_eff not held by a lower neighbor
   always_comb begin
      pick    = '0;
      pick_ok = 1'b0;
      for (int c = COLOR_SPAN - 1; c >= 1; c--) begin
         if (!used_ff[c] && (START_W'(c) >= start_ff) && (COLOR_W'(c) <= c_eff)) begin
            pick    = COLOR_W'(c);
            pick_ok = 1'b1;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_kind) inside
                  REQ_SET_EDGE, REQ_CLEAR_EDGE: begin
                     state_in = bad_node ? S_SINGLE_RSP : S_EDGE_A_WR;
                  end
                  REQ_START: begin
                     state_in = (n_eff == '0) ? S_SINGLE_RSP : S_ROW_RD;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_EDGE_A_WR: begin
            state_in = (clear_ff && !adj_row[b_ff]) ? S_SINGLE_RSP : S_EDGE_B_RD;
         end
         S_EDGE_B_RD:  state_in = S_EDGE_B_WR;
         S_EDGE_B_WR:  state_in = S_SINGLE_RSP;
         S_SINGLE_RSP: state_in = slot_free ? S_IDLE : S_SINGLE_RSP;
         S_ROW_RD:     state_in = S_ROW_CAP;
         S_ROW_CAP:    state_in = S_SCAN;
         S_SCAN:       state_in = (!scan_more && !pend_ff) ? S_PICK : S_SCAN;
         S_PICK: begin
            if (pick_ok) begin
               state_in = (cur_ff == n_eff) ? S_OUT_RD : S_ROW_RD;
            end else begin
               state_in = (cur_ff == NW'(1)) ? S_SINGLE_RSP : S_BACK;
            end
         end
         S_BACK:       state_in = S_ROW_RD;
         S_OUT_RD:     state_in = S_OUT_EMIT;
         S_OUT_EMIT: begin
            if (slot_free) begin
               state_in = out_last ? S_IDLE : S_OUT_RD;
            end
         end
         default:      state_in = S_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      a_in      = a_ff;
      b_in      = b_ff;
      clear_in  = clear_ff;
      status_in = status_ff;
      cur_in    = cur_ff;
      start_in  = start_ff;
      scan_in   = scan_ff;
      pend_in   = pend_ff;
      used_in   = used_ff;
      row_in    = row_ff;
      radr_in   = radr_ff;
      valid_in  = valid_ff;
      out_in    = out_ff;
      req_ready = 1'b0;
      emit      = '0;
      adj_we    = 1'b0;
      adj_waddr = a_ff;
      adj_wdata = '0;
      adj_re    = 1'b0;
      adj_raddr = a_ff;
      col_we    = 1'b0;
      col_waddr = AW'(cur_ff - NW'(1));
      col_wdata = pick;
      col_re    = 1'b0;
      col_raddr = AW'(scan_ff - NW'(1));

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            a_in      = AW'(node_a - NODE_W'(1));
            b_in      = AW'(node_b - NODE_W'(1));
            clear_in  = req_kind == REQ_CLEAR_EDGE;
            cur_in    = NW'(1);
            start_in  = START_W'(1);
            if (accept) begin
               case (req_kind) inside
                  REQ_SET_EDGE, REQ_CLEAR_EDGE: begin
                     status_in = ST_BAD_NODE;
                     adj_re    = !bad_node;
                     adj_raddr = AW'(node_a - NODE_W'(1));
                     radr_in   = AW'(node_a - NODE_W'(1));
                  end
                  REQ_START: begin
                     status_in = ST_FOUND;
                  end
                  default: status_in = status_ff;
               endcase
            end
         end
         S_EDGE_A_WR: begin
            if (clear_ff && !adj_row[b_ff]) begin
               status_in = ST_NOT_ADJ;
            end else begin
               adj_we       = 1'b1;
               adj_waddr    = a_ff;
               adj_wdata    = clear_ff ? (adj_row & ~one_hot_b) : (adj_row | one_hot_b);
               valid_in[a_ff] = 1'b1;
            end
         end
         S_EDGE_B_RD: begin
            adj_re    = 1'b1;
            adj_raddr = b_ff;
            radr_in   = b_ff;
         end
         S_EDGE_B_WR: begin
            adj_we         = 1'b1;
            adj_waddr      = b_ff;
            adj_wdata      = clear_ff ? (adj_row & ~one_hot_a) : (adj_row | one_hot_a);
            valid_in[b_ff] = 1'b1;
            status_in      = ST_EDGE_OK;
         end
         S_SINGLE_RSP: begin
            emit.valid  = slot_free;
            emit.status = status_ff;
            emit.last   = 1'b1;
         end
         S_ROW_RD: begin
            adj_re    = 1'b1;
            adj_raddr = AW'(cur_ff - NW'(1));
            radr_in   = AW'(cur_ff - NW'(1));
         end
         S_ROW_CAP: begin
            row_in  = adj_row;
            scan_in = NW'(1);
            pend_in = 1'b0;
            used_in = '0;
         end
         S_SCAN: begin
            // a read issued last cycle lands now
            if (pend_ff) begin
               used_in = used_ff | (COLOR_SPAN'(1) << col_rdata);
            end
            if (scan_more) begin
               col_re  = row_ff[AW'(scan_ff - NW'(1))];
               pend_in = row_ff[AW'(scan_ff - NW'(1))];
               scan_in = scan_ff + NW'(1);
            end else begin
               pend_in = 1'b0;
            end
         end
         S_PICK: begin
            if (pick_ok) begin
               col_we   = 1'b1;
               start_in = START_W'(1);
               if (cur_ff == n_eff) begin
                  out_in = NW'(1);
               end else begin
                  cur_in = cur_ff + NW'(1);
               end
            end else if (cur_ff == NW'(1)) begin
               status_in = ST_NONE;
            end else begin
               // step back and resume after the previous node's color
               cur_in    = cur_ff - NW'(1);
               col_re    = 1'b1;
               col_raddr = AW'(cur_ff - NW'(2));
            end
         end
         S_BACK: begin
            start_in = START_W'(col_rdata) + START_W'(1);
         end
         S_OUT_RD: begin
            col_re    = 1'b1;
            col_raddr = AW'(out_ff - NW'(1));
         end
         S_OUT_EMIT: begin
            emit.valid  = slot_free;
            emit.status = ST_FOUND;
            emit.node   = NODE_W'(out_ff);
            emit.color  = col_rdata;
            emit.last   = out_last;
            if (slot_free) begin
               out_in = out_ff + NW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      b_ff      <= b_in;
      clear_ff  <= clear_in;
      status_ff <= status_in;
      cur_ff    <= cur_in;
      start_ff  <= start_in;
      scan_ff   <= scan_in;
      used_ff   <= used_in;
      row_ff    <= row_in;
      radr_ff   <= radr_in;
      out_ff    <= out_in;
   end

endmodule

// ===== src/graph_coloring_backtrack_unit.sv =====
// ----------------------------------------------------------------------------
// graph_coloring_backtrack_unit
// adjacency matrix with edge set/clear and a backtracking graph coloring search
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_tvalid/req_tready | tuser kind, tdata node_a node_b
//  rsp     | out       | rsp_tvalid/rsp_tready | tuser status, tdata node color, tlast
//  csr     | in        | csr_valid/csr_ready   | csr_index, csr_wdata
//
//  set or clear edge: read row a, write it, read row b, write it, respond;
//  a bad node responds without any ram access, a missing edge without any write
//  search: each node visit reads its row, then reads the color of each lower node
//  that is a neighbor, one at a time through the single read port of the color ram,
//  then picks a color; a backtrack adds a read of the previous node's color
//  success sends one result per node, each a color ram read, then a send
//  reset: control state clears at once, adjacency rows read empty until written
//  a stalled rsp channel holds the search at its next send; one result waits in the
//  output register while the next request is taken
// ----------------------------------------------------------------------------
module graph_coloring_backtrack_unit
   import gcb_pkg::*;
#(
   parameter int MAX_NODES  = DEF_MAX_NODES,
   parameter int MAX_COLORS = DEF_MAX_COLORS
) (
   input  logic              clock,
   input  logic              reset,
   // request stream
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // node_a[5:0], node_b[11:6], zero[15:12]
   input  logic [TYPE_W-1:0] req_tuser,   // req_type[1:0]
   // result stream
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // node[5:0], color[9:6], zero[15:10]
   output logic [STATUS_W-1:0] rsp_tuser, // status[2:0]
   output logic              rsp_tlast,
   // register writes
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [NODE_W-1:0] csr_wdata
);

   localparam int NW = $clog2(MAX_NODES + 1);
   localparam int AW = $clog2(MAX_NODES);

   // configuration registers
   logic [NODE_W-1:0]  node_count_ff, node_count_in;
   logic [COLOR_W-1:0] color_count_ff, color_count_in;
   logic [NW-1:0]      n_eff;
   logic [COLOR_W-1:0] c_eff;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   gcb_status_type     rsp_status_ff, rsp_status_in;
   logic [NODE_W-1:0]  rsp_node_ff, rsp_node_in;
   logic [COLOR_W-1:0] rsp_color_ff, rsp_color_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               slot_free;
   gcb_rsp_type        emit;

   // ram connections
   logic                 adj_we, adj_re;
   logic [AW-1:0]        adj_waddr, adj_raddr;
   logic [MAX_NODES-1:0] adj_wdata, adj_rdata;
   logic                 col_we, col_re;
   logic [AW-1:0]        col_waddr, col_raddr;
   logic [COLOR_W-1:0]   col_wdata, col_rdata;

   assign csr_ready = 1'b1;

   // register write decode
   always_comb begin
      node_count_in  = node_count_ff;
      color_count_in = color_count_ff;
      if (csr_valid) begin
         unique case (gcb_csr_type'(csr_index))
            CSR_NODE_COUNT:  node_count_in  = csr_wdata;
            CSR_COLOR_COUNT: color_count_in = csr_wdata[COLOR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff  <= NODE_COUNT_RESET;
         color_count_ff <= COLOR_COUNT_RESET;
      end else begin
         node_count_ff  <= node_count_in;
         color_count_ff <= color_count_in;
      end
   end

   // oversized counts saturate at the build limits
   assign n_eff = (CMP_W'(node_count_ff) > CMP_W'(MAX_NODES)) ?
                  NW'(MAX_NODES) : NW'(node_count_ff);
   assign c_eff = (color_count_ff > COLOR_W'(MAX_COLORS)) ?
                  COLOR_W'(MAX_COLORS) : color_count_ff;

   // one-deep output register, loads when empty or draining
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_node_in   = rsp_node_ff;
      rsp_color_in  = rsp_color_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit.valid) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = emit.status;
         rsp_node_in   = emit.node;
         rsp_color_in  = emit.color;
         rsp_last_in   = emit.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_node_ff   <= rsp_node_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(DATA_W - NODE_W - COLOR_W){1'b0}}, rsp_color_ff, rsp_node_ff};

   // sequencer
   gcb_ctrl #(
      .MAX_NODES (MAX_NODES),
      .NW        (NW),
      .AW        (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_kind  (req_tuser),
      .node_a    (req_tdata[NODE_A_LSB +: NODE_W]),
      .node_b    (req_tdata[NODE_B_LSB +: NODE_W]),
      .n_eff     (n_eff),
      .c_eff     (c_eff),
      .slot_free (slot_free),
      .emit      (emit),
      .adj_we    (adj_we),
      .adj_waddr (adj_waddr),
      .adj_wdata (adj_wdata),
      .adj_re    (adj_re),
      .adj_raddr (adj_raddr),
      .adj_rdata (adj_rdata),
      .col_we    (col_we),
      .col_waddr (col_waddr),
      .col_wdata (col_wdata),
      .col_re    (col_re),
      .col_raddr (col_raddr),
      .col_rdata (col_rdata)
   );

   // one adjacency row per node
   gcb_ram #(
      .WIDTH (MAX_NODES),
      .DEPTH (MAX_NODES),
      .AW    (AW)
   ) u_adj_ram (
      .clock   (clock),
      .wr_en   (adj_we),
      .wr_addr (adj_waddr),
      .wr_data (adj_wdata),
      .rd_en   (adj_re),
      .rd_addr (adj_raddr),
      .rd_data (adj_rdata)
   );

   // color per node, only read where written during the current search
   gcb_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (MAX_NODES),
      .AW    (AW)
   ) u_col_ram (
      .clock   (clock),
      .wr_en   (col_we),
      .wr_addr (col_waddr),
      .wr_data (col_wdata),
      .rd_en   (col_re),
      .rd_addr (col_raddr),
      .rd_data (col_rdata)
   );

endmodule

// ===== src/gcb_checker.sv =====
// ----------------------------------------------------------------------------
// gcb_checker
// port level checks of the graph coloring backtrack unit
// ----------------------------------------------------------------------------
module gcb_checker
   import gcb_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic [TYPE_W-1:0]   req_tuser,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [DATA_W-1:0]   rsp_tdata,
   input logic [STATUS_W-1:0] rsp_tuser,
   input logic                rsp_tlast
);

   // a stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   // every real request leaves the unit busy in the cycle after it is taken
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready &&
      (req_tuser == REQ_SET_EDGE || req_tuser == REQ_CLEAR_EDGE || req_tuser == REQ_START)
      |=> !req_tready)
      else $error("request taken while previous one still in flight");

   // edge and failure results are single, carry no node and no color
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_FOUND |-> rsp_tlast && rsp_tdata == '0)
      else $error("non coloring result with payload or without last");

   // a reported node always holds a real color
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_FOUND && rsp_tdata[RSP_NODE_LSB +: NODE_W] != '0
      |-> rsp_tdata[RSP_COLOR_LSB +: COLOR_W] != '0)
      else $error("colored node reported with color zero");

endmodule

bind graph_coloring_backtrack_unit gcb_checker u_gcb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
